// ----- rtl/box_filter_rgb_stream_macros.svh -----
// Assertion macros shared by the box filter RTL.
// Included by box_filter_rgb_stream for its assertions; no other dependencies.
`ifndef BOX_FILTER_RGB_STREAM_MACROS_SVH
`define BOX_FILTER_RGB_STREAM_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define BFRGB_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define BFRGB_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- rtl/bfrgb_pkg.sv -----
// Package for the RGB box filter: payload structs, register codes, widths and
// the reciprocal lookup used by the mean divider. No dependencies.
package bfrgb_pkg;

   localparam int MAX_RADIUS_DEF = 7;
   localparam int MAX_WIDTH_DEF  = 1024;
   localparam int MAX_HEIGHT     = 4096;

   localparam int PIX_W   = 8;
   localparam int PIX_MAX = 255;

   localparam int CFG_RADIUS_W = 3;
   localparam int CFG_WIDTH_W  = 11;
   localparam int CFG_HEIGHT_W = 13;

   localparam logic [CFG_RADIUS_W-1:0] RADIUS_RESET = 3'd1;
   localparam logic [CFG_WIDTH_W-1:0]  WIDTH_RESET  = 11'd1024;
   localparam logic [CFG_HEIGHT_W-1:0] HEIGHT_RESET = 13'd1024;

   localparam int COL_OUT_W = 10;
   localparam int ROW_W     = 12;

   localparam int CSR_AW  = 4;
   localparam int CSR_DW  = 32;
   localparam int CSR_IW  = CSR_AW - 2;

   localparam logic [CSR_IW-1:0] REG_RADIUS = 2'd0;
   localparam logic [CSR_IW-1:0] REG_WIDTH  = 2'd1;
   localparam logic [CSR_IW-1:0] REG_HEIGHT = 2'd2;

   // Reciprocals are floor(2^RECIP_SHIFT / n) for n = (2r+1)^2.
   localparam int RECIP_SHIFT = 24;
   localparam int RECIP_W     = 21;
   localparam int RECIP_IDX_W = 4;

   localparam int DEF_STORE_ROWS = 2 * MAX_RADIUS_DEF + 1;
   localparam int DEF_T_W = $clog2(DEF_STORE_ROWS * DEF_STORE_ROWS * (PIX_MAX + 1));
   localparam int DEF_N_W = $clog2(DEF_STORE_ROWS * DEF_STORE_ROWS + 1);

   typedef struct packed {
      logic [PIX_W-1:0] red_in;
      logic [PIX_W-1:0] green_in;
      logic [PIX_W-1:0] blue_in;
   } req_payload_type;

   typedef struct packed {
      logic [COL_OUT_W-1:0] col_out;
      logic [ROW_W-1:0]     row_out;
      logic [PIX_W-1:0]     red_out;
      logic [PIX_W-1:0]     green_out;
      logic [PIX_W-1:0]     blue_out;
      logic                 frame_last;
   } rsp_payload_type;

   function automatic logic [RECIP_W-1:0] mean_recip(input logic [RECIP_IDX_W-1:0] rad);
      logic [RECIP_W-1:0] m;
      unique case (rad)
         4'd1:    m = 21'd1864135;
         4'd2:    m = 21'd671088;
         4'd3:    m = 21'd342392;
         4'd4:    m = 21'd207126;
         4'd5:    m = 21'd138654;
         4'd6:    m = 21'd99273;
         4'd7:    m = 21'd74565;
         4'd8:    m = 21'd58052;
         4'd9:    m = 21'd46474;
         4'd10:   m = 21'd38043;
         4'd11:   m = 21'd31714;
         4'd12:   m = 21'd26843;
         4'd13:   m = 21'd23014;
         4'd14:   m = 21'd19949;
         4'd15:   m = 21'd17458;
         default: m = '0;
      endcase
      return m;
   endfunction

endpackage

// ----- rtl/bfrgb_mean_div.sv -----
// Two-stage divider for one color channel: window sum over window size.
// Depends on bfrgb_pkg (reciprocal width and shift, pixel width).
module bfrgb_mean_div #(
   parameter int T_W = bfrgb_pkg::DEF_T_W,
   parameter int N_W = bfrgb_pkg::DEF_N_W
) (
   input  logic                             clock,
   input  logic [T_W-1:0]                   t_in,
   input  logic [bfrgb_pkg::RECIP_W-1:0]    recip_in,
   input  logic [N_W-1:0]                   n_in,
   output logic [bfrgb_pkg::PIX_W-1:0]      mean_out
);
   import bfrgb_pkg::*;

   localparam int PW    = T_W + RECIP_W;
   localparam int CHK_W = PIX_W + N_W;

   logic [PW-1:0]    prod_ff;
   logic [T_W-1:0]   t1_ff;
   logic [T_W-1:0]   t2_ff;
   logic [PIX_W-1:0] qe_ff;
   logic [CHK_W-1:0] chk_ff;
   logic [PIX_W-1:0] qe_in;
   logic [CHK_W-1:0] rem_in;
   logic             corr_in;

   // The estimate is never above the true quotient and at most one below it.
   assign qe_in = prod_ff[RECIP_SHIFT +: PIX_W];

   always_ff @(posedge clock) begin
      prod_ff <= PW'(t_in) * PW'(recip_in);
      t1_ff   <= t_in;
      qe_ff   <= qe_in;
      chk_ff  <= CHK_W'(qe_in) * CHK_W'(n_in);
      t2_ff   <= t1_ff;
   end

   assign rem_in   = CHK_W'(t2_ff) - chk_ff;
   assign corr_in  = (rem_in >= CHK_W'(n_in));
   assign mean_out = qe_ff + PIX_W'(corr_in);

endmodule

// ----- rtl/box_filter_rgb_stream.sv -----
// Top level of the streaming RGB box filter with line store and column sums.
// Depends on bfrgb_pkg, bfrgb_mean_div and box_filter_rgb_stream_macros.svh.
//
// Usage: pixels enter in raster order on the req_ channel (valid/ready), one
// request per pixel. Each interior pixel whose full square window lies in the
// image produces one response on the rsp_ channel with the centre coordinates
// and the rounded channel means; border pixels produce nothing.
// Steps: an interior pixel goes through accumulate, multiply, fix and output
// before the next pixel is accepted, and its response is registered as it leaves
// output; a border pixel goes through accumulate only. The steps follow the
// column-sum read-modify-write and the two-stage reciprocal divider.
// The response sits in an output register, so a stalled receiver holds only
// that register: the next pixel is accepted and processed, and the block waits
// in its final step only if a second result is ready before the first is taken.
// Reset restores radius 1 and a 1024 x 1024 image and starts at pixel (0,0).
// Any CSR write also restarts the image. No memory clearing pass is needed:
// the first row of each image overwrites the column sums, and the line store
// is read only at rows written earlier in the same image.
// CSR map: radius at 0x0, image_width at 0x4, image_height at 0x8.
`include "box_filter_rgb_stream_macros.svh"

module box_filter_rgb_stream #(
   parameter int MAX_RADIUS = bfrgb_pkg::MAX_RADIUS_DEF,
   parameter int MAX_WIDTH  = bfrgb_pkg::MAX_WIDTH_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  bfrgb_pkg::req_payload_type       req_payload,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output bfrgb_pkg::rsp_payload_type       rsp_payload,
   input  logic                             csr_psel,
   input  logic                             csr_penable,
   input  logic                             csr_pwrite,
   input  logic [bfrgb_pkg::CSR_AW-1:0]     csr_paddr,
   input  logic [bfrgb_pkg::CSR_DW-1:0]     csr_pwdata,
   output logic [bfrgb_pkg::CSR_DW-1:0]     csr_prdata,
   output logic                             csr_pready
);
   import bfrgb_pkg::*;

   localparam int STORE_ROWS = 2 * MAX_RADIUS + 1;
   localparam int RW       = $clog2(MAX_RADIUS + 1);
   localparam int RCMP     = (RW > CFG_RADIUS_W) ? RW : CFG_RADIUS_W;
   localparam int SPAN_W   = RW + 1;
   localparam int CW       = $clog2(MAX_WIDTH);
   localparam int WCW      = $clog2(MAX_WIDTH + 1);
   localparam int WCMP     = (WCW > CFG_WIDTH_W) ? WCW : CFG_WIDTH_W;
   localparam int CC_W     = ((CW > SPAN_W) ? CW : SPAN_W) + 1;
   localparam int SW       = $clog2(STORE_ROWS);
   localparam int OS_W     = SW + 1;
   localparam int LS_DEPTH = STORE_ROWS * MAX_WIDTH;
   localparam int LS_AW    = $clog2(LS_DEPTH);
   localparam int CSUM_W   = $clog2(STORE_ROWS * PIX_MAX + 1);
   localparam int WSUM_W   = $clog2(STORE_ROWS * STORE_ROWS * PIX_MAX + 1);
   localparam int N_W      = $clog2(STORE_ROWS * STORE_ROWS + 1);
   localparam int T_W      = $clog2(STORE_ROWS * STORE_ROWS * (PIX_MAX + 1));

   typedef enum logic [2:0] {
      S_IDLE,
      S_ACC,
      S_MUL,
      S_FIX,
      S_OUT
   } state_type;

   // Configuration registers and derived values.
   logic [CFG_RADIUS_W-1:0] radius_ff;
   logic [CFG_WIDTH_W-1:0]  width_ff;
   logic [CFG_HEIGHT_W-1:0] height_ff;
   logic                    csr_write;
   logic [CSR_IW-1:0]       csr_index;
   logic [RCMP-1:0]         radius_wide;
   logic [RW-1:0]           r_eff;
   logic [SPAN_W-1:0]       span;
   logic [SPAN_W:0]         side;
   logic [N_W-1:0]          n_val;
   logic [N_W-1:0]          half_val;
   logic [RECIP_W-1:0]      recip_val;
   logic [WCMP-1:0]         width_wide;
   logic [WCW-1:0]          w_eff;
   logic [CFG_HEIGHT_W-1:0] h_eff;

   // Raster position of the next pixel.
   logic [CW-1:0]    col_ff, col_in;
   logic [ROW_W-1:0] row_ff, row_in;
   logic [SW-1:0]    slot_ff, slot_in;
   logic             last_col, last_row;

   // Request decode at acceptance.
   logic             req_accept;
   logic             col_ge_span, col_gt_span;
   logic [CW-1:0]    old_col;
   logic [SW-1:0]    old_slot;
   logic [LS_AW-1:0] ls_rd_addr;

   // Per-item registers.
   logic [2:0][PIX_W-1:0]  pix_ff;
   logic [CW-1:0]          cur_col_ff;
   logic [ROW_W-1:0]       cur_row_ff;
   logic [LS_AW-1:0]       ls_wr_addr_ff;
   logic                   fresh_col_ff, sub_pix_ff, fresh_win_ff, sub_col_ff;
   logic                   emit_ff, last_ff;

   // Memories and their read registers.
   logic [2:0][PIX_W-1:0]  line_mem [LS_DEPTH];
   logic [2:0][CSUM_W-1:0] col_mem [MAX_WIDTH];
   logic [2:0][PIX_W-1:0]  ls_rd_ff;
   logic [2:0][CSUM_W-1:0] cs_cur_ff;
   logic [2:0][CSUM_W-1:0] cs_old_ff;

   // Sums and divider.
   logic [2:0][CSUM_W-1:0] colsum_in;
   logic [2:0][WSUM_W-1:0] win_ff, win_in;
   logic [2:0][T_W-1:0]    t_ff;
   logic [2:0][PIX_W-1:0]  mean;

   state_type       state_ff;
   logic            rsp_valid_ff;
   rsp_payload_type rsp_payload_ff;
   rsp_payload_type rsp_in;

   // ---------------------------------------------------------------- CSR port
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_index  = csr_paddr[CSR_AW-1:2];

   always_ff @(posedge clock) begin
      if (reset) begin
         radius_ff <= RADIUS_RESET;
         width_ff  <= WIDTH_RESET;
         height_ff <= HEIGHT_RESET;
      end else if (csr_write) begin
         unique case (csr_index)
            REG_RADIUS: radius_ff <= csr_pwdata[CFG_RADIUS_W-1:0];
            REG_WIDTH:  width_ff  <= csr_pwdata[CFG_WIDTH_W-1:0];
            REG_HEIGHT: height_ff <= csr_pwdata[CFG_HEIGHT_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_index)
         REG_RADIUS: csr_prdata = CSR_DW'(radius_ff);
         REG_WIDTH:  csr_prdata = CSR_DW'(width_ff);
         REG_HEIGHT: csr_prdata = CSR_DW'(height_ff);
         default:    csr_prdata = '0;
      endcase
   end

   // Out-of-range settings are clamped to what the hardware supports.
   assign radius_wide = RCMP'(radius_ff);
   assign width_wide  = WCMP'(width_ff);

   always_comb begin
      priority if (radius_wide == '0) begin
         r_eff = RW'(1);
      end else if (radius_wide > RCMP'(MAX_RADIUS)) begin
         r_eff = RW'(MAX_RADIUS);
      end else begin
         r_eff = RW'(radius_wide);
      end
      priority if (width_wide == '0) begin
         w_eff = WCW'(1);
      end else if (width_wide > WCMP'(MAX_WIDTH)) begin
         w_eff = WCW'(MAX_WIDTH);
      end else begin
         w_eff = WCW'(width_wide);
      end
      priority if (height_ff == '0) begin
         h_eff = CFG_HEIGHT_W'(1);
      end else if (height_ff > CFG_HEIGHT_W'(MAX_HEIGHT)) begin
         h_eff = CFG_HEIGHT_W'(MAX_HEIGHT);
      end else begin
         h_eff = height_ff;
      end
   end

   assign span      = {r_eff, 1'b0};
   assign side      = (SPAN_W + 1)'(span) + (SPAN_W + 1)'(1);
   assign n_val     = N_W'(side) * N_W'(side);
   assign half_val  = (n_val - N_W'(1)) >> 1;
   assign recip_val = mean_recip(RECIP_IDX_W'(r_eff));

   // ---------------------------------------------------------- raster counters
   assign req_ready  = (state_ff == S_IDLE);
   assign req_accept = req_valid && req_ready;

   assign last_col = (WCW'(col_ff) == w_eff - WCW'(1));
   assign last_row = (CFG_HEIGHT_W'(row_ff) == h_eff - CFG_HEIGHT_W'(1));

   always_comb begin
      col_in  = col_ff + CW'(1);
      row_in  = row_ff;
      slot_in = slot_ff;
      if (last_col) begin
         col_in = '0;
         if (last_row) begin
            row_in  = '0;
            slot_in = '0;
         end else begin
            row_in  = row_ff + ROW_W'(1);
            slot_in = (slot_ff == SW'(STORE_ROWS - 1)) ? '0 : slot_ff + SW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset || csr_write) begin
         col_ff  <= '0;
         row_ff  <= '0;
         slot_ff <= '0;
      end else if (req_accept) begin
         col_ff  <= col_in;
         row_ff  <= row_in;
         slot_ff <= slot_in;
      end
   end

   // ----------------------------------------------------------- memory access
   assign col_ge_span = (CC_W'(col_ff) >= CC_W'(span));
   assign col_gt_span = (CC_W'(col_ff) > CC_W'(span));
   assign old_col     = col_ff - CW'(span) - CW'(1);

   // Line-store row that leaves the window when this row enters it.
   always_comb begin
      if (OS_W'(slot_ff) >= OS_W'(span) + OS_W'(1)) begin
         old_slot = SW'(OS_W'(slot_ff) - OS_W'(span) - OS_W'(1));
      end else begin
         old_slot = SW'(OS_W'(slot_ff) + OS_W'(STORE_ROWS) - OS_W'(span) - OS_W'(1));
      end
   end

   assign ls_rd_addr = LS_AW'(old_slot) * LS_AW'(MAX_WIDTH) + LS_AW'(col_ff);

   always_ff @(posedge clock) begin
      if (req_accept) begin
         ls_rd_ff  <= line_mem[ls_rd_addr];
         cs_cur_ff <= col_mem[col_ff];
         cs_old_ff <= col_mem[old_col];
      end
      if (state_ff == S_ACC) begin
         line_mem[ls_wr_addr_ff] <= pix_ff;
         col_mem[cur_col_ff]     <= colsum_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         pix_ff        <= {req_payload.red_in, req_payload.green_in, req_payload.blue_in};
         cur_col_ff    <= col_ff;
         cur_row_ff    <= row_ff;
         ls_wr_addr_ff <= LS_AW'(slot_ff) * LS_AW'(MAX_WIDTH) + LS_AW'(col_ff);
         fresh_col_ff  <= (row_ff == '0);
         sub_pix_ff    <= (row_ff > ROW_W'(span));
         fresh_win_ff  <= (col_ff == '0);
         sub_col_ff    <= col_gt_span;
         emit_ff       <= col_ge_span && (row_ff >= ROW_W'(span));
         last_ff       <= last_col && last_row;
      end
   end

   // ----------------------------------------------------------- running sums
   // Intermediate wrap-around is harmless: each final sum fits its width.
   always_comb begin
      for (int ch = 0; ch < 3; ch++) begin
         colsum_in[ch] = (fresh_col_ff ? '0 : cs_cur_ff[ch]) + CSUM_W'(pix_ff[ch])
                         - (sub_pix_ff ? CSUM_W'(ls_rd_ff[ch]) : '0);
         win_in[ch]    = (fresh_win_ff ? '0 : win_ff[ch]) + WSUM_W'(colsum_in[ch])
                         - (sub_col_ff ? WSUM_W'(cs_old_ff[ch]) : '0);
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == S_ACC) begin
         win_ff <= win_in;
         for (int ch = 0; ch < 3; ch++) begin
            t_ff[ch] <= T_W'(win_in[ch]) + T_W'(half_val);
         end
      end
   end

   for (genvar g = 0; g < 3; g++) begin : g_div
      bfrgb_mean_div #(
         .T_W (T_W),
         .N_W (N_W)
      ) u_div (
         .clock    (clock),
         .t_in     (t_ff[g]),
         .recip_in (recip_val),
         .n_in     (n_val),
         .mean_out (mean[g])
      );
   end

   // -------------------------------------------------------- control and output
   always_comb begin
      rsp_in.col_out    = COL_OUT_W'(cur_col_ff - CW'(r_eff));
      rsp_in.row_out    = cur_row_ff - ROW_W'(r_eff);
      rsp_in.red_out    = mean[2];
      rsp_in.green_out  = mean[1];
      rsp_in.blue_out   = mean[0];
      rsp_in.frame_last = last_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         // A new result takes the output register in the cycle the old one leaves.
         if (state_ff == S_OUT && (!rsp_valid_ff || rsp_ready)) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            S_IDLE: begin
               if (req_accept) begin
                  state_ff <= S_ACC;
               end
            end
            S_ACC: begin
               state_ff <= emit_ff ? S_MUL : S_IDLE;
            end
            S_MUL: begin
               state_ff <= S_FIX;
            end
            S_FIX: begin
               state_ff <= S_OUT;
            end
            S_OUT: begin
               if (!rsp_valid_ff || rsp_ready) begin
                  rsp_payload_ff <= rsp_in;
                  state_ff       <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

   // ---------------------------------------------------------------- checks
   `BFRGB_ASSERT_NEXT(a_accept_to_acc, clock, reset, req_accept, state_ff == S_ACC, "accepted request did not enter accumulate step")
   `BFRGB_ASSERT_IMP(a_col_in_range, clock, reset, 1'b1, WCW'(col_ff) < w_eff, "column counter beyond image width")
   `BFRGB_ASSERT_IMP(a_slot_in_range, clock, reset, 1'b1, OS_W'(slot_ff) < OS_W'(STORE_ROWS), "line store slot out of range")
   `BFRGB_ASSERT_IMP(a_slot_row_zero, clock, reset, row_ff == '0, slot_ff == '0, "line store slot not aligned with first row")
   `BFRGB_ASSERT_NEXT(a_result_held, clock, reset, state_ff == S_OUT && rsp_valid_ff && !rsp_ready, state_ff == S_OUT, "pending result dropped while output stalled")

endmodule

// ----- dv/tb_top.sv -----
// Self-checking testbench for the streaming RGB box filter (box_filter_rgb_stream).
// Depends on bfrgb_pkg for the payload structs, register codes and widths.
// Raster images of random pixels go in; each window mean is predicted and checked.
`timescale 1ns / 100ps

module tb_top;
   import bfrgb_pkg::*;

   localparam logic [CSR_IW-1:0] REG_SPARE = 2'd3;
   localparam int SETTLE_CYCLES  = 16;
   localparam int HOLD_CYCLES    = 200;
   localparam int RANDOM_TARGET  = 600;
   localparam int PHASE_CAP      = 400;

   // Predicts the window means from the pixel stream and checks responses in order.
   class blur_scoreboard;
      req_payload_type           pix_rows [DEF_STORE_ROWS][MAX_WIDTH_DEF];
      logic [CFG_RADIUS_W-1:0]   radius_reg;
      logic [CFG_WIDTH_W-1:0]    width_reg;
      logic [CFG_HEIGHT_W-1:0]   height_reg;
      int unsigned               col_next;
      int unsigned               row_next;
      rsp_payload_type           pending_means[$];
      int unsigned               mismatch_count;

      function new();
         radius_reg = RADIUS_RESET;
         width_reg = WIDTH_RESET;
         height_reg = HEIGHT_RESET;
         col_next = 0;
         row_next = 0;
         mismatch_count = 0;
      endfunction

      // Any register write, even to an unused index, restarts the image.
      function void apply_reg(logic [CSR_IW-1:0] idx, logic [CSR_DW-1:0] value);
         case (idx)
            REG_RADIUS: radius_reg = value[CFG_RADIUS_W-1:0];
            REG_WIDTH:  width_reg = value[CFG_WIDTH_W-1:0];
            REG_HEIGHT: height_reg = value[CFG_HEIGHT_W-1:0];
            default: ;
         endcase
         col_next = 0;
         row_next = 0;
      endfunction

      function int unsigned round_mean(int unsigned sum, int unsigned n);
         int unsigned m;
         m = (2 * sum + n) / (2 * n);
         return (m > PIX_MAX) ? PIX_MAX : m;
      endfunction

      function void note_pixel(req_payload_type px);
         int unsigned r, w, h, span, n, c, y, dy, dx, slot;
         int unsigned sum_r, sum_g, sum_b;
         req_payload_type p;
         rsp_payload_type e;
         r = (radius_reg == 0) ? 1 : (radius_reg > MAX_RADIUS_DEF) ? MAX_RADIUS_DEF : radius_reg;
         w = (width_reg == 0) ? 1 : (width_reg > MAX_WIDTH_DEF) ? MAX_WIDTH_DEF : width_reg;
         h = (height_reg == 0) ? 1 : (height_reg > MAX_HEIGHT) ? MAX_HEIGHT : height_reg;
         c = col_next;
         y = row_next;
         span = 2 * r;
         pix_rows[y % DEF_STORE_ROWS][c] = px;
         if (c >= span && y >= span) begin
            sum_r = 0;
            sum_g = 0;
            sum_b = 0;
            n = (span + 1) * (span + 1);
            for (dy = 0; dy <= span; dy++) begin
               slot = (y - span + dy) % DEF_STORE_ROWS;
               for (dx = 0; dx <= span; dx++) begin
                  p = pix_rows[slot][c - span + dx];
                  sum_r += p.red_in;
                  sum_g += p.green_in;
                  sum_b += p.blue_in;
               end
            end
            e.col_out = COL_OUT_W'(c - r);
            e.row_out = ROW_W'(y - r);
            e.red_out = PIX_W'(round_mean(sum_r, n));
            e.green_out = PIX_W'(round_mean(sum_g, n));
            e.blue_out = PIX_W'(round_mean(sum_b, n));
            e.frame_last = (c == w - 1) && (y == h - 1);
            pending_means.push_back(e);
         end
         c++;
         if (c >= w) begin
            c = 0;
            y++;
            if (y >= h) y = 0;
         end
         col_next = c;
         row_next = y;
      endfunction

      function void compare_field(string field_name, int unsigned want, int unsigned got);
         if (want != got) begin
            $error("%s: expected %0d, actual %0d", field_name, want, got);
            mismatch_count++;
         end
      endfunction

      function void check_pixel_mean(rsp_payload_type got);
         rsp_payload_type e;
         if (pending_means.size() == 0) begin
            $error("response with none expected: col_out %0d, row_out %0d",
                   got.col_out, got.row_out);
            mismatch_count++;
            return;
         end
         e = pending_means.pop_front();
         compare_field("col_out", e.col_out, got.col_out);
         compare_field("row_out", e.row_out, got.row_out);
         compare_field("red_out", e.red_out, got.red_out);
         compare_field("green_out", e.green_out, got.green_out);
         compare_field("blue_out", e.blue_out, got.blue_out);
         compare_field("frame_last", e.frame_last, got.frame_last);
      endfunction
   endclass

   logic                  clock;
   logic                  reset;
   logic                  req_valid;
   logic                  req_ready;
   req_payload_type       req_payload;
   logic                  rsp_valid;
   logic                  rsp_ready;
   rsp_payload_type       rsp_payload;
   logic                  csr_psel;
   logic                  csr_penable;
   logic                  csr_pwrite;
   logic [CSR_AW-1:0]     csr_paddr;
   logic [CSR_DW-1:0]     csr_pwdata;
   logic [CSR_DW-1:0]     csr_prdata;
   logic                  csr_pready;

   blur_scoreboard        sb;
   bit                    idle_off;
   bit                    hold_request;
   int unsigned           random_items;

   box_filter_rgb_stream dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   initial begin
      #4_000_000;
      $display("tb_top: FAIL");
      $finish;
   end

   // Mostly short gaps, a few long ones; none while idling is switched off.
   function automatic int unsigned pick_gap();
      int unsigned p;
      p = $urandom_range(0, 99);
      if (idle_off || p < 60) return 0;
      if (p < 90) return $urandom_range(1, 3);
      if (p < 98) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   function automatic req_payload_type random_pixel();
      req_payload_type px;
      px = req_payload_type'($urandom);
      if ($urandom_range(0, 9) == 0) begin
         px.red_in = $urandom_range(0, 1) ? 8'hff : 8'h00;
         px.green_in = $urandom_range(0, 1) ? 8'hff : 8'h00;
         px.blue_in = $urandom_range(0, 1) ? 8'hff : 8'h00;
      end
      return px;
   endfunction

   // Both directions are sampled at the same edge, so a request is always
   // noted before the response it causes can appear.
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && req_ready) sb.note_pixel(req_payload);
         if (rsp_valid && rsp_ready) sb.check_pixel_mean(rsp_payload);
      end
   end

   // Receiver: random stalls, plus one long hold-off when asked for.
   initial begin
      int unsigned stall_left;
      int unsigned hold_left;
      bit          hold_taken;
      stall_left = 0;
      hold_left = 0;
      hold_taken = 1'b0;
      rsp_ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_left > 0) begin
            rsp_ready <= 1'b0;
            hold_left--;
         end else if (hold_request && !hold_taken) begin
            hold_taken = 1'b1;
            hold_left = HOLD_CYCLES - 1;
            rsp_ready <= 1'b0;
         end else if (stall_left > 0) begin
            rsp_ready <= 1'b0;
            stall_left--;
         end else begin
            rsp_ready <= 1'b1;
            if ($urandom_range(0, 99) < 25) stall_left = pick_gap();
         end
      end
   end

   task automatic wait_idle();
      while (sb.pending_means.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IW-1:0] idx, input logic [CSR_DW-1:0] value);
      wait_idle();
      @(negedge clock);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= {idx, 2'b00};
      csr_pwdata <= value;
      @(negedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      sb.apply_reg(idx, value);
      @(negedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   // Entered and left at a falling edge.
   task automatic send_pixel(input req_payload_type px);
      int unsigned gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_payload <= px;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic send_pixels(input int unsigned count);
      int unsigned i;
      for (i = 0; i < count; i++) send_pixel(random_pixel());
      req_valid <= 1'b0;
   endtask

   task automatic run_random_phase(output int unsigned sent);
      logic [CFG_RADIUS_W-1:0] rad;
      logic [CFG_WIDTH_W-1:0]  wid;
      logic [CFG_HEIGHT_W-1:0] hgt;
      int unsigned pick, r_eff, w_eff, h_eff, count;
      pick = $urandom_range(0, 9);
      rad = (pick == 0) ? 3'd0 : (pick == 1) ? 3'd7 : CFG_RADIUS_W'($urandom_range(1, 3));
      r_eff = (rad == 0) ? 1 : rad;
      case ($urandom_range(0, 19))
         0: wid = '0;
         1: wid = CFG_WIDTH_W'($urandom_range(1, 2));
         2: wid = CFG_WIDTH_W'($urandom_range(1025, 2047));
         3: wid = CFG_WIDTH_W'(MAX_WIDTH_DEF);
         default: wid = CFG_WIDTH_W'($urandom_range(2 * r_eff + 1, 2 * r_eff + 24));
      endcase
      case ($urandom_range(0, 19))
         0: hgt = '0;
         1: hgt = CFG_HEIGHT_W'($urandom_range(4097, 8191));
         2: hgt = CFG_HEIGHT_W'($urandom_range(1, 2));
         default: hgt = CFG_HEIGHT_W'($urandom_range(2 * r_eff + 1, 2 * r_eff + 10));
      endcase
      w_eff = (wid == 0) ? 1 : (wid > MAX_WIDTH_DEF) ? MAX_WIDTH_DEF : wid;
      h_eff = (hgt == 0) ? 1 : (hgt > MAX_HEIGHT) ? MAX_HEIGHT : hgt;
      // Upper register bits are random; only the low bits should matter.
      if ($urandom_range(0, 99) < 85)
         write_reg(REG_RADIUS, ($urandom << CFG_RADIUS_W) | rad);
      if ($urandom_range(0, 99) < 85)
         write_reg(REG_WIDTH, ($urandom << CFG_WIDTH_W) | wid);
      if ($urandom_range(0, 99) < 85)
         write_reg(REG_HEIGHT, ($urandom << CFG_HEIGHT_W) | hgt);
      if ($urandom_range(0, 99) < 15) write_reg(REG_SPARE, $urandom);
      count = w_eff * h_eff * $urandom_range(1, 2) + $urandom_range(0, w_eff);
      if (count > PHASE_CAP) count = $urandom_range(PHASE_CAP / 2, PHASE_CAP);
      idle_off = ($urandom_range(0, 5) == 0);
      wait_idle();
      @(negedge clock);
      send_pixels(count);
      sent = count;
   endtask

   initial begin
      req_payload_type px;
      int unsigned i, sent;
      sb = new();
      reset = 1'b1;
      req_valid = 1'b0;
      req_payload = '0;
      csr_psel = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite = 1'b0;
      csr_paddr = '0;
      csr_pwdata = '0;
      idle_off = 1'b0;
      hold_request = 1'b0;
      random_items = 0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Smallest image: one window of full-scale pixels.
      write_reg(REG_RADIUS, 1);
      write_reg(REG_WIDTH, 3);
      write_reg(REG_HEIGHT, 3);
      @(negedge clock);
      for (i = 0; i < 9; i++) send_pixel('1);
      req_valid <= 1'b0;

      // A window larger than the image never completes.
      write_reg(REG_RADIUS, 7);
      @(negedge clock);
      send_pixels(3);

      // Radius zero behaves as one; the spare register write restarts the image.
      write_reg(REG_RADIUS, 0);
      @(negedge clock);
      send_pixels(2);
      write_reg(REG_SPARE, 0);
      @(negedge clock);
      for (i = 0; i < 9; i++) begin
         px.red_in = (i == 4) ? 8'hff : 8'h00;
         px.green_in = 8'h00;
         px.blue_in = i[0] ? 8'hff : 8'h00;
         send_pixel(px);
      end
      req_valid <= 1'b0;

      // Long receiver hold-off while requests keep coming.
      write_reg(REG_RADIUS, 1);
      write_reg(REG_WIDTH, 8);
      write_reg(REG_HEIGHT, 8);
      idle_off = 1'b1;
      @(negedge clock);
      hold_request = 1'b1;
      send_pixels(64);

      // Largest radius over more rows than the line store holds.
      write_reg(REG_RADIUS, 7);
      write_reg(REG_WIDTH, 18);
      write_reg(REG_HEIGHT, 17);
      @(negedge clock);
      send_pixels(18 * 17);

      // One full-width row and the start of the next.
      write_reg(REG_RADIUS, 1);
      write_reg(REG_WIDTH, MAX_WIDTH_DEF);
      write_reg(REG_HEIGHT, 3);
      @(negedge clock);
      send_pixels(MAX_WIDTH_DEF + 4);
      idle_off = 1'b0;

      while (random_items < RANDOM_TARGET) begin
         run_random_phase(sent);
         random_items += sent;
      end

      wait_idle();
      if (sb.mismatch_count == 0 && sb.pending_means.size() == 0) begin
         $display("tb_top: PASS");
      end else begin
         $display("tb_top: FAIL");
      end
      $finish;
   end

endmodule
